// ===== design/crs_spmv_pkg.sv =====
// crs_spmv_pkg: shared widths, codes and defaults of the COO row-segmented SpMV block.
// No dependencies; every other design file but crs_spmv_checker refers to it by scoped names.
`default_nettype none
package crs_spmv_pkg;

    localparam int DATA_W  = 32;
    localparam int ACC_W   = 48;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 16;
    localparam int PROD_W  = 2 * DATA_W;

    localparam int VECTOR_DEPTH_DEF = 1024;
    localparam int ROW_BITS_DEF     = 16;

    localparam int FIFO_DEPTH = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ENTRY = 1'b1;

endpackage
`default_nettype wire

// ===== design/crs_spmv_fifo.sv =====
// crs_spmv_fifo: short register queue between the front and back parts.
// Depth from crs_spmv_pkg::FIFO_DEPTH (power of two); width set by the instantiating level.
`default_nettype none
module crs_spmv_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  empty
);
    localparam int PTR_W = $clog2(crs_spmv_pkg::FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] slot_reg [crs_spmv_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign full     = (count_reg == CNT_W'(crs_spmv_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);

endmodule
`default_nettype wire

// ===== design/crs_spmv_front.sv =====
// crs_spmv_front: accepts items, wraps the slot index, owns the vector store.
// Loads write the store; nonzeros read it and go to the queue. Uses crs_spmv_pkg.
`default_nettype none
module crs_spmv_front #(
    parameter int VECTOR_DEPTH = crs_spmv_pkg::VECTOR_DEPTH_DEF,
    parameter int RW           = crs_spmv_pkg::ROW_W,
    localparam int ENT_W       = RW + 2 * crs_spmv_pkg::DATA_W + 1
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_operation,
    input  wire logic [crs_spmv_pkg::COL_W-1:0]    s_column_or_slot,
    input  wire logic [crs_spmv_pkg::ROW_W-1:0]    s_row,
    input  wire logic [crs_spmv_pkg::DATA_W-1:0]   s_value,
    input  wire logic                              s_last,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output logic      [ENT_W-1:0]                  q_data
);
    localparam int IDX_W = $clog2(VECTOR_DEPTH);
    localparam int DW    = crs_spmv_pkg::DATA_W;
    localparam int CW    = crs_spmv_pkg::COL_W;

    logic [DW-1:0] vec_mem [VECTOR_DEPTH];

    logic          a_valid_reg;
    logic          a_op_reg;
    logic [CW-1:0] a_col_reg;
    logic [RW-1:0] a_row_reg;
    logic [DW-1:0] a_value_reg;
    logic          a_last_reg;

    logic          b_valid_reg;
    logic [RW-1:0] b_row_reg;
    logic [DW-1:0] b_value_reg;
    logic          b_last_reg;
    logic [DW-1:0] vec_rd_reg;

    logic             adv;
    logic             a_load;
    logic [IDX_W-1:0] idx;

    assign adv     = !b_valid_reg || !q_full;
    assign a_load  = adv || !a_valid_reg;
    assign s_ready = a_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_load) begin
                a_valid_reg <= s_valid;
            end
            if (adv) begin
                b_valid_reg <= a_valid_reg && (a_op_reg == crs_spmv_pkg::OP_ENTRY);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load && s_valid) begin
            a_op_reg    <= s_operation;
            a_col_reg   <= s_column_or_slot;
            a_row_reg   <= s_row[RW-1:0];
            a_value_reg <= s_value;
            a_last_reg  <= s_last;
        end
        if (adv) begin
            b_row_reg   <= a_row_reg;
            b_value_reg <= a_value_reg;
            b_last_reg  <= a_last_reg;
        end
    end

    if (VECTOR_DEPTH >= (1 << CW)) begin : g_direct
        assign idx = IDX_W'(a_col_reg);
    end else begin : g_wrap
        localparam int RECIP = ((1 << 20) + VECTOR_DEPTH - 1) / VECTOR_DEPTH;
        logic [30:0]   q_prod;
        logic [CW-1:0] q_reg;
        logic [19:0]   q_times_d;
        logic [19:0]   diff;

        // quotient by reciprocal, exact for every 10-bit column value
        assign q_prod = 31'(s_column_or_slot) * 31'(RECIP);

        always_ff @(posedge aclk) begin
            if (a_load && s_valid) begin
                q_reg <= q_prod[29:20];
            end
        end

        assign q_times_d = 20'(q_reg) * 20'(VECTOR_DEPTH);
        assign diff      = 20'(a_col_reg) - q_times_d;
        assign idx       = diff[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv && a_valid_reg && (a_op_reg == crs_spmv_pkg::OP_LOAD)) begin
            vec_mem[idx] <= a_value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && a_valid_reg && (a_op_reg == crs_spmv_pkg::OP_ENTRY)) begin
            vec_rd_reg <= vec_mem[idx];
        end
    end

    assign q_push = b_valid_reg && !q_full;
    assign q_data = {b_row_reg, b_value_reg, vec_rd_reg, b_last_reg};

endmodule
`default_nettype wire

// ===== design/crs_spmv_back.sv =====
// crs_spmv_back: multiplies, accumulates per row and emits finished row sums.
// Pulls entries from crs_spmv_fifo; uses crs_spmv_pkg widths.
`default_nettype none
module crs_spmv_back #(
    parameter int RW     = crs_spmv_pkg::ROW_W,
    localparam int ENT_W = RW + 2 * crs_spmv_pkg::DATA_W + 1
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              q_empty,
    input  wire logic [ENT_W-1:0]                  q_data,
    output logic                                   q_pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [crs_spmv_pkg::ROW_W-1:0]    m_out_row,
    output logic      [crs_spmv_pkg::DATA_W-1:0]   m_row_sum,
    output logic                                   m_final_res
);
    localparam int DW = crs_spmv_pkg::DATA_W;
    localparam int AW = crs_spmv_pkg::ACC_W;
    localparam int PW = crs_spmv_pkg::PROD_W;

    function automatic logic signed [AW-1:0] sat_acc(input logic signed [AW:0] v);
        logic signed [AW-1:0] r;
        if (v[AW] != v[AW-1]) begin
            r = v[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            r = v[AW-1:0];
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] sat_out(input logic signed [AW-1:0] v);
        logic [DW-1:0] r;
        if ((&v[AW-1:DW-1]) || !(|v[AW-1:DW-1])) begin
            r = v[DW-1:0];
        end else begin
            r = v[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction

    logic                 e_last;
    logic [RW-1:0]        e_row;
    logic signed [DW-1:0] e_value;
    logic signed [DW-1:0] e_vec;

    logic                 mv_reg;
    logic signed [PW-1:0] prod_reg;
    logic [RW-1:0]        m_row_reg;
    logic                 m_last_reg;

    logic                 open_reg;
    logic [RW-1:0]        cur_row_reg;
    logic signed [AW-1:0] acc_reg;

    logic                 r0_v_reg, r1_v_reg;
    logic [RW-1:0]        r0_row_reg, r1_row_reg;
    logic signed [AW-1:0] r0_acc_reg, r1_acc_reg;
    logic                 r0_fin_reg;

    logic                 pair_free;
    logic                 go;
    logic                 m_adv;
    logic                 take;
    logic                 change;
    logic signed [AW-1:0] prod48;
    logic signed [AW-1:0] base;
    logic signed [AW:0]   sum;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] sel_acc;
    logic [RW-1:0]        sel_row;

    assign e_row   = q_data[ENT_W-1 -: RW];
    assign e_value = q_data[2*DW -: DW];
    assign e_vec   = q_data[DW -: DW];
    assign e_last  = q_data[0];

    assign take      = m_valid && m_ready;
    assign pair_free = (!r0_v_reg && !r1_v_reg) || (m_ready && (r0_v_reg != r1_v_reg));
    assign go        = mv_reg && pair_free;
    assign m_adv     = !mv_reg || pair_free;
    assign q_pop     = !q_empty && m_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (m_adv) begin
            mv_reg <= !q_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            prod_reg   <= e_value * e_vec;
            m_row_reg  <= e_row;
            m_last_reg <= e_last;
        end
    end

    // floor shift of Q32.32 to Q32.16 always fits the accumulator
    assign prod48   = prod_reg[PW-1:16];
    assign change   = open_reg && (m_row_reg != cur_row_reg);
    assign base     = (open_reg && !change) ? acc_reg : '0;
    assign sum      = {base[AW-1], base} + {prod48[AW-1], prod48};
    assign acc_next = sat_acc(sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg    <= 1'b0;
            cur_row_reg <= '0;
            acc_reg     <= '0;
        end else if (go) begin
            cur_row_reg <= m_row_reg;
            if (m_last_reg) begin
                open_reg <= 1'b0;
                acc_reg  <= '0;
            end else begin
                open_reg <= 1'b1;
                acc_reg  <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_v_reg <= 1'b0;
            r1_v_reg <= 1'b0;
        end else if (go) begin
            r0_v_reg <= change || m_last_reg;
            r1_v_reg <= change && m_last_reg;
        end else if (take) begin
            if (r0_v_reg) begin
                r0_v_reg <= 1'b0;
            end else begin
                r1_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            r0_row_reg <= change ? cur_row_reg : m_row_reg;
            r0_acc_reg <= change ? acc_reg : acc_next;
            r0_fin_reg <= !change;
            r1_row_reg <= m_row_reg;
            r1_acc_reg <= acc_next;
        end
    end

    assign sel_acc     = r0_v_reg ? r0_acc_reg : r1_acc_reg;
    assign sel_row     = r0_v_reg ? r0_row_reg : r1_row_reg;
    assign m_valid     = r0_v_reg || r1_v_reg;
    assign m_row_sum   = sat_out(sel_acc);
    assign m_out_row   = crs_spmv_pkg::ROW_W'(sel_row);
    assign m_final_res = r0_v_reg ? r0_fin_reg : 1'b1;

endmodule
`default_nettype wire

// ===== design/coo_row_segmented_spmv.sv =====
// COO row-segmented sparse matrix times vector, Q16.16 in and out.
// Input channel s_*: operation 0 loads s_value into vector slot s_column_or_slot;
// operation 1 is a nonzero (row, column, value), rows ascending, s_last on the final one.
// Output channel m_*: one transaction per finished row (out_row, saturated row_sum),
// m_final_res set on the row that ends the matrix. Empty rows produce nothing.
// Throughput: one input transaction per cycle while s_ready is high; a nonzero that
// both closes a row and carries last yields two results and holds the back end until
// one is taken. Path of a nonzero: a and b registers, queue, product, result registers.
// The single-port vector store is accessed at most once per cycle, by a load write or a
// nonzero read, and the 48-bit accumulate loop is a single adder back into acc_reg.
// Reset (aresetn low, synchronous): no row open, accumulator zero, queues empty.
// The vector store is not cleared and holds undefined data until loaded.
// When m_ready is low, results wait in a two-entry result register, then the
// 4-entry queue fills, then s_ready drops; nothing is lost or repeated.
// Depends on crs_spmv_pkg, crs_spmv_front, crs_spmv_fifo, crs_spmv_back.
`default_nettype none
module coo_row_segmented_spmv #(
    parameter int VECTOR_DEPTH = crs_spmv_pkg::VECTOR_DEPTH_DEF,
    parameter int ROW_BITS     = crs_spmv_pkg::ROW_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_operation,
    input  wire logic [crs_spmv_pkg::COL_W-1:0]    s_column_or_slot,
    input  wire logic [crs_spmv_pkg::ROW_W-1:0]    s_row,
    input  wire logic [crs_spmv_pkg::DATA_W-1:0]   s_value,
    input  wire logic                              s_last,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [crs_spmv_pkg::ROW_W-1:0]    m_out_row,
    output logic      [crs_spmv_pkg::DATA_W-1:0]   m_row_sum,
    output logic                                   m_final_res
);
    localparam int RW    = (ROW_BITS < crs_spmv_pkg::ROW_W) ? ROW_BITS : crs_spmv_pkg::ROW_W;
    localparam int ENT_W = RW + 2 * crs_spmv_pkg::DATA_W + 1;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [ENT_W-1:0] q_wdata;
    logic [ENT_W-1:0] q_rdata;

    crs_spmv_front #(
        .VECTOR_DEPTH (VECTOR_DEPTH),
        .RW           (RW)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_column_or_slot (s_column_or_slot),
        .s_row            (s_row),
        .s_value          (s_value),
        .s_last           (s_last),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_wdata)
    );

    crs_spmv_fifo #(
        .WIDTH (ENT_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    crs_spmv_back #(
        .RW (RW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_row_sum   (m_row_sum),
        .m_final_res (m_final_res)
    );

endmodule
`default_nettype wire

// ===== design/crs_spmv_checker.sv =====
// crs_spmv_checker: port-level assertions for coo_row_segmented_spmv, bound to the top level.
// Sees only the top-level ports; no package dependency.
`default_nettype none
module crs_spmv_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_operation,
    input wire logic [9:0]  s_column_or_slot,
    input wire logic [15:0] s_row,
    input wire logic [31:0] s_value,
    input wire logic        s_last,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_out_row,
    input wire logic [31:0] m_row_sum,
    input wire logic        m_final_res
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result transaction dropped while stalled");

    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_row) && $stable(m_row_sum)
                                && $stable(m_final_res))
        else $error("result payload changed while stalled");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_operation)
                                && $stable(s_column_or_slot) && $stable(s_row)
                                && $stable(s_value) && $stable(s_last))
        else $error("input transaction changed while waiting");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind coo_row_segmented_spmv crs_spmv_checker u_crs_spmv_checker (.*);
`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for coo_row_segmented_spmv (valid/ready in and out).
// Predicts row sums from a local vector store and 48-bit row accumulator.
// Depends on crs_spmv_pkg and the coo_row_segmented_spmv design files.
`timescale 1ns / 1ps
module tb_top;

    localparam int  ROW_W  = crs_spmv_pkg::ROW_W;
    localparam int  DATA_W = crs_spmv_pkg::DATA_W;
    localparam int  COL_W  = crs_spmv_pkg::COL_W;

    localparam int  CYCLE_LIMIT = 200000;
    localparam int  DRAIN_CYCLES = 20;
    localparam longint ACC_HI = 64'sd140737488355327;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint SUM_HI = 64'sd2147483647;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] sum;
        logic              fin;
    } row_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_operation;
    logic [COL_W-1:0]    s_column_or_slot;
    logic [ROW_W-1:0]    s_row;
    logic [DATA_W-1:0]   s_value;
    logic                s_last;
    logic                m_valid;
    logic                m_ready;
    logic [ROW_W-1:0]    m_out_row;
    logic [DATA_W-1:0]   m_row_sum;
    logic                m_final_res;

    // predictor state
    logic [DATA_W-1:0]   vec_mem [crs_spmv_pkg::VECTOR_DEPTH_DEF];
    bit                  slot_loaded [crs_spmv_pkg::VECTOR_DEPTH_DEF];
    logic [COL_W-1:0]    loaded_slots[$];
    longint              acc_q;
    logic [ROW_W-1:0]    open_row;
    bit                  row_live;
    row_result_t         expected_rows[$];

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int rows_checked;
    int err_count;
    int cycle_count;

    coo_row_segmented_spmv u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_column_or_slot (s_column_or_slot),
        .s_row            (s_row),
        .s_value          (s_value),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_row        (m_out_row),
        .m_row_sum        (m_row_sum),
        .m_final_res      (m_final_res)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic row_result_t finished_row(input logic [ROW_W-1:0] row, input longint acc,
                                                 input logic fin);
        row_result_t r;
        longint s;
        s = clamp(acc, SUM_LO, SUM_HI);
        r.row = row;
        r.sum = s[DATA_W-1:0];
        r.fin = fin;
        return r;
    endfunction

    task automatic model_accept(input logic op, input logic [COL_W-1:0] col,
                                input logic [ROW_W-1:0] row, input logic [DATA_W-1:0] val,
                                input logic lst);
        longint a;
        longint b;
        longint prod;
        if (op == crs_spmv_pkg::OP_LOAD) begin
            vec_mem[col] = val;
            if (!slot_loaded[col]) begin
                slot_loaded[col] = 1'b1;
                loaded_slots.push_back(col);
            end
        end else begin
            a = $signed(val);
            b = $signed(vec_mem[col]);
            prod = (a * b) >>> 16;
            if (row_live && row != open_row) begin
                expected_rows.push_back(finished_row(open_row, acc_q, 1'b0));
                row_live = 1'b0;
            end
            if (row_live) begin
                acc_q = clamp(acc_q + prod, ACC_LO, ACC_HI);
            end else begin
                acc_q = clamp(prod, ACC_LO, ACC_HI);
                open_row = row;
                row_live = 1'b1;
            end
            if (lst) begin
                expected_rows.push_back(finished_row(open_row, acc_q, 1'b1));
                row_live = 1'b0;
                acc_q = 0;
            end
        end
    endtask

    // one transaction; valid stays high into the next call unless that call idles
    task automatic send_item(input logic op, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row, input logic [DATA_W-1:0] val,
                             input logic lst);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= op;
        s_column_or_slot <= col;
        s_row            <= row;
        s_value          <= val;
        s_last           <= lst;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        model_accept(op, col, row, val, lst);
        items_sent++;
    endtask

    task automatic load_slot(input logic [COL_W-1:0] slot, input logic [DATA_W-1:0] val);
        send_item(crs_spmv_pkg::OP_LOAD, slot, ROW_W'($urandom), val, 1'($urandom));
    endtask

    task automatic send_entry(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                              input logic [DATA_W-1:0] val, input logic lst);
        send_item(crs_spmv_pkg::OP_ENTRY, col, row, val, lst);
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [COL_W-1:0] pick_column();
        return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
    endfunction

    // hold valid low until every expected row sum has come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_rows.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_idle_pct = 28;
        recv_idle_pct = 70;
        send_item(crs_spmv_pkg::OP_LOAD, 10'd0,    16'd0, 32'h8000_0000, 1'b0);
        send_item(crs_spmv_pkg::OP_LOAD, 10'd1023, 16'd0, 32'h7FFF_FFFF, 1'b0);
        send_item(crs_spmv_pkg::OP_LOAD, 10'd1,    16'd0, 32'h0001_0000, 1'b0);
        // last mark on a load is ignored
        send_item(crs_spmv_pkg::OP_LOAD, 10'd2,    16'hFFFF, 32'hFFFF_0000, 1'b1);
        send_entry(16'd0, 10'd1, 32'h0003_8000, 1'b0);
        send_entry(16'd0, 10'd2, 32'h0001_0000, 1'b0);
        // row change to the top row; accumulator hits the 48-bit ceiling
        send_entry(16'hFFFF, 10'd0, 32'h8000_0000, 1'b0);
        send_entry(16'hFFFF, 10'd0, 32'h8000_0000, 1'b0);
        send_entry(16'hFFFF, 10'd0, 32'h8000_0000, 1'b0);
        send_entry(16'hFFFF, 10'd2, 32'h7FFF_FFFF, 1'b0);
        // decreasing row, negative saturation
        send_entry(16'd5, 10'd1023, 32'h8000_0000, 1'b0);
        send_entry(16'd5, 10'd1023, 32'h8000_0000, 1'b0);
        send_entry(16'd5, 10'd1023, 32'h8000_0000, 1'b0);
        // last together with a row change: two results
        send_entry(16'd6, 10'd1, 32'h0000_0001, 1'b1);
        // floor rounding of a tiny negative product
        send_item(crs_spmv_pkg::OP_LOAD, 10'd3, 16'd0, 32'hFFFF_FFFF, 1'b0);
        send_entry(16'd7, 10'd3, 32'h0000_0001, 1'b1);
        send_entry(16'd8, 10'd1, 32'h0000_0000, 1'b0);
        send_entry(16'd8, 10'd3, 32'hFFFF_FFFF, 1'b1);
        // same row number right after last starts a new matrix
        send_entry(16'd8, 10'd0, 32'h0000_0000, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
        int stop_at;
        int n_rows;
        int per_row;
        logic [ROW_W-1:0] r;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: stray load or entry with an arbitrary row and last
                if ($urandom_range(0, 1) == 0)
                    load_slot(COL_W'($urandom), rand_value());
                else
                    send_entry(ROW_W'($urandom), pick_column(), rand_value(), 1'($urandom));
            end else begin
                r = ($urandom_range(0, 3) == 0) ? ROW_W'($urandom) : ROW_W'($urandom_range(0, 15));
                n_rows = $urandom_range(1, 6);
                for (int i = 0; i < n_rows; i++) begin
                    per_row = $urandom_range(1, 4);
                    for (int k = 0; k < per_row; k++) begin
                        if ($urandom_range(0, 3) == 0)
                            load_slot(COL_W'($urandom), rand_value());
                        send_entry(r, pick_column(), rand_value(),
                                   (i == n_rows - 1) && (k == per_row - 1));
                    end
                    r = r + ROW_W'(($urandom_range(0, 3) == 0) ? $urandom_range(2, 500) : 1);
                end
            end
        end
        wait_results_drained();
    endtask

    task automatic test_drain_pause();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_entry(16'd40, pick_column(), rand_value(), 1'b0);
        send_entry(16'd40, pick_column(), rand_value(), 1'b0);
        send_entry(16'd41, pick_column(), rand_value(), 1'b0);
        // hold with row 41 still open
        wait_results_drained();
        send_entry(16'd41, pick_column(), rand_value(), 1'b0);
        send_entry(16'd42, pick_column(), rand_value(), 1'b1);
        wait_results_drained();
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        row_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual row=%0d sum=%h final=%0b",
                         $time, m_out_row, m_row_sum, m_final_res);
                err_count++;
            end else begin
                want = expected_rows.pop_front();
                rows_checked++;
                if (m_out_row !== want.row) begin
                    $display("%0t: out_row mismatch: expected %0d actual %0d",
                             $time, want.row, m_out_row);
                    err_count++;
                end
                if (m_row_sum !== want.sum) begin
                    $display("%0t: row_sum mismatch (row %0d): expected %h actual %h",
                             $time, want.row, want.sum, m_row_sum);
                    err_count++;
                end
                if (m_final_res !== want.fin) begin
                    $display("%0t: final_res mismatch (row %0d): expected %0b actual %0b",
                             $time, want.row, want.fin, m_final_res);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("coo_row_segmented_spmv test failed");
            $finish;
        end
    end

    initial begin
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_operation      <= crs_spmv_pkg::OP_LOAD;
        s_column_or_slot <= '0;
        s_row            <= '0;
        s_value          <= '0;
        s_last           <= 1'b0;
        m_ready          <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent    = 0;
        rows_checked  = 0;
        err_count     = 0;
        cycle_count   = 0;
        acc_q         = 0;
        open_row      = '0;
        row_live      = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(28, 70, 270);
        test_random_traffic(70, 28, 270);
        test_random_traffic(0, 0, 260);
        test_drain_pause();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d input transactions, checked %0d row results", items_sent, rows_checked);
        $display("Covered loads, saturation, row changes, last flushes and three idle profiles");
        if (err_count == 0 && expected_rows.size() == 0) begin
            $display("coo_row_segmented_spmv test passed");
        end else begin
            $display("coo_row_segmented_spmv test failed");
        end
        $finish;
    end

endmodule

// ===== coo_row_segmented_spmv.f =====
design/crs_spmv_pkg.sv
design/crs_spmv_fifo.sv
design/crs_spmv_front.sv
design/crs_spmv_back.sv
design/coo_row_segmented_spmv.sv
design/crs_spmv_checker.sv
dv/tb_top.sv
